// File: src/csot_pkg.sv
// Package for the capsule-sphere overlap test.
// Holds the register index codes and the derived axis word shared by the
// setup sequencer, the datapath pipeline and the top level.
package csot_pkg;

  // Configuration register indexes.
  localparam logic [7:0] REG_CAPSULE_X = 8'd0;
  localparam logic [7:0] REG_CAPSULE_Y = 8'd1;
  localparam logic [7:0] REG_CAPSULE_Z = 8'd2;
  localparam logic [7:0] REG_AXIS_X    = 8'd3;
  localparam logic [7:0] REG_AXIS_Y    = 8'd4;
  localparam logic [7:0] REG_AXIS_Z    = 8'd5;
  localparam logic [7:0] REG_SEG_LEN   = 8'd6;
  localparam logic [7:0] REG_RADIUS    = 8'd7;

  // Number of fraction bits of the unit axis (Q2.30).
  localparam int UnitFrac = 30;

  // Unit axis handed from the setup sequencer to the pipeline.
  typedef struct packed {
    logic            busy;
    logic [2:0]      neg;
    logic [2:0][30:0] mag;
  } unit_axis_t;

endpackage

// File: src/csot_setup.sv
// Setup sequencer: derives the Q2.30 unit axis from the axis registers.
// Runs a bit-serial square root and a restoring divider. Uses csot_pkg.
module csot_setup (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2:0][31:0]      axis,
  output csot_pkg::unit_axis_t  unit
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SQ   = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_DIV  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [63:0]      sq_r, sq_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [63:0]      x_r, x_nxt;
  logic [63:0]      res_r, res_nxt;
  logic [31:0]      n_r, n_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [30:0]      q_r, q_nxt;
  logic [2:0][30:0] mag_r, mag_nxt;
  logic [2:0]       neg_r, neg_nxt;

  logic [2:0][31:0] amag;
  logic [63:0]      root_bit;
  logic [63:0]      root_try;
  logic [32:0]      rem2;

  // Magnitude of each axis component.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag[i] = axis[i][31] ? (32'd0 - axis[i]) : axis[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    sq_nxt    = sq_r;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    res_nxt   = res_r;
    n_nxt     = n_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    root_bit  = 64'd1 << {cnt_r, 1'b0};
    root_try  = res_r + root_bit;
    rem2      = {rem_r, (cnt_r == 5'd30) ? amag[idx_r][0] : 1'b0};

    if (start) begin
      // A new axis restarts the whole derivation.
      state_nxt = ST_SQ;
      cnt_nxt   = 5'd0;
      acc_nxt   = 64'd0;
    end else begin
      case (state_r)
        ST_IDLE: begin
        end
        // Sum of squares, one component a cycle.
        ST_SQ: begin
          if (cnt_r != 5'd0) begin
            acc_nxt = acc_r + sq_r;
          end
          if (cnt_r != 5'd3) begin
            sq_nxt  = amag[cnt_r[1:0]] * amag[cnt_r[1:0]];
            cnt_nxt = cnt_r + 5'd1;
          end else begin
            state_nxt = ST_ROOT;
            x_nxt     = acc_r + sq_r;
            res_nxt   = 64'd0;
            cnt_nxt   = 5'd31;
          end
        end
        // Integer square root, one result bit a cycle.
        ST_ROOT: begin
          if (x_r >= root_try) begin
            x_nxt   = x_r - root_try;
            res_nxt = (res_r >> 1) + root_bit;
          end else begin
            res_nxt = res_r >> 1;
          end
          if (cnt_r == 5'd0) begin
            n_nxt     = res_nxt[31:0];
            state_nxt = ST_DIV;
            idx_nxt   = 2'd0;
            cnt_nxt   = 5'd30;
            rem_nxt   = {1'b0, amag[0][31:1]};
          end else begin
            cnt_nxt = cnt_r - 5'd1;
          end
        end
        // Restoring division of |axis| << 30 by the norm, one bit a cycle.
        ST_DIV: begin
          if (n_r == 32'd0) begin
            mag_nxt   = '0;
            neg_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            if (rem2 >= {1'b0, n_r}) begin
              rem_nxt = 32'(rem2 - {1'b0, n_r});
              q_nxt   = {q_r[29:0], 1'b1};
            end else begin
              rem_nxt = rem2[31:0];
              q_nxt   = {q_r[29:0], 1'b0};
            end
            if (cnt_r == 5'd0) begin
              mag_nxt[idx_r] = q_nxt;
              neg_nxt[idx_r] = axis[idx_r][31];
              if (idx_r == 2'd2) begin
                state_nxt = ST_IDLE;
              end else begin
                idx_nxt = idx_r + 2'd1;
                cnt_nxt = 5'd30;
                rem_nxt = {1'b0, amag[idx_r + 2'd1][31:1]};
              end
            end else begin
              cnt_nxt = cnt_r - 5'd1;
            end
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mag_r   <= '0;
      neg_r   <= '0;
      cnt_r   <= 5'd0;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sq_r  <= sq_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    res_r <= res_nxt;
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign unit.busy = (state_r != ST_IDLE);
  assign unit.neg  = neg_r;
  assign unit.mag  = mag_r;

endmodule

// File: src/csot_pipe.sv
// Seven-stage distance pipeline, one sphere word per cycle while en is high.
// Projects onto the unit axis, clamps, and compares the squared distance.
// Uses csot_pkg for the unit axis word.
module csot_pipe (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_take,
  input  logic [2:0][31:0]     sphere,
  input  logic [30:0]          sphere_rad,
  input  logic [2:0][31:0]     center,
  input  logic [30:0]          seg_len,
  input  logic [30:0]          cap_rad,
  input  csot_pkg::unit_axis_t unit,
  output logic                 valid_out,
  output logic                 hit_out
);

  logic [6:0] val_r;

  // Stage 1: offsets and radius sum.
  logic [2:0][32:0] v1_r;
  logic [31:0]      rs1_r;
  // Stage 2: projection products and squared radius sum.
  logic [2:0][63:0] pr2_r;
  logic [2:0]       pn2_r;
  logic [2:0][32:0] v2_r;
  logic [63:0]      r2_2_r;
  // Stage 3: clamped doubled parameter.
  logic [31:0]      t2_3_r;
  logic [2:0][32:0] v3_r;
  logic [63:0]      r2_3_r;
  // Stage 4: axis offsets of the nearest segment point.
  logic [2:0][30:0] m4_r;
  logic [2:0]       mn4_r;
  logic [2:0][32:0] v4_r;
  logic [63:0]      r2_4_r;
  // Stage 5: distance components.
  logic [2:0][31:0] wm5_r;
  logic             far5_r;
  logic [63:0]      r2_5_r;
  // Stage 6: squares.
  logic [2:0][63:0] sq6_r;
  logic             far6_r;
  logic [63:0]      r2_6_r;
  // Stage 7: result.
  logic             hit7_r;

  logic [2:0][32:0] v_c;
  logic [2:0][32:0] vmag_c;
  logic [2:0][63:0] pr_c;
  logic [36:0]      p_c;
  logic [37:0]      t2x_c;
  logic [37:0]      lim_c;
  logic [31:0]      t2_c;
  logic [31:0]      t2mag_c;
  logic [2:0][61:0] m_c;
  logic [2:0][34:0] w_c;
  logic [2:0][34:0] wmag_c;
  logic             far_c;
  logic [65:0]      d2_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_c[i]    = 33'($signed({sphere[i][31], sphere[i]})
                      - $signed({center[i][31], center[i]}));
      vmag_c[i] = v1_r[i][32] ? (33'd0 - v1_r[i]) : v1_r[i];
      pr_c[i]   = 64'(vmag_c[i] * unit.mag[i]);
    end
  end

  // Signed projection and clamp to the segment.
  always_comb begin
    p_c = '0;
    for (int i = 0; i < 3; i++) begin
      if (pn2_r[i]) begin
        p_c = p_c - {3'd0, pr2_r[i][63:csot_pkg::UnitFrac]};
      end else begin
        p_c = p_c + {3'd0, pr2_r[i][63:csot_pkg::UnitFrac]};
      end
    end
    t2x_c = {p_c, 1'b0};
    lim_c = {7'd0, seg_len};
    if ($signed(t2x_c) > $signed(lim_c)) begin
      t2_c = {1'b0, seg_len};
    end else if ($signed(t2x_c) < -$signed(lim_c)) begin
      t2_c = 32'd0 - {1'b0, seg_len};
    end else begin
      t2_c = t2x_c[31:0];
    end
    t2mag_c = t2_3_r[31] ? (32'd0 - t2_3_r) : t2_3_r;
    for (int i = 0; i < 3; i++) begin
      m_c[i] = 62'(t2mag_c * unit.mag[i]);
    end
  end

  // Distance components and the far flag.
  always_comb begin
    far_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (mn4_r[i]) begin
        w_c[i] = {{2{v4_r[i][32]}}, v4_r[i]} + {4'd0, m4_r[i]};
      end else begin
        w_c[i] = {{2{v4_r[i][32]}}, v4_r[i]} - {4'd0, m4_r[i]};
      end
      wmag_c[i] = w_c[i][34] ? (35'd0 - w_c[i]) : w_c[i];
      if (wmag_c[i][34:32] != 3'd0) begin
        far_c = 1'b1;
      end
    end
    d2_c = {2'd0, sq6_r[0]} + {2'd0, sq6_r[1]} + {2'd0, sq6_r[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (en) begin
      val_r <= {val_r[5:0], in_take};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r   <= v_c;
      rs1_r  <= {1'b0, cap_rad} + {1'b0, sphere_rad};
      for (int i = 0; i < 3; i++) begin
        pn2_r[i] <= v1_r[i][32] ^ unit.neg[i];
      end
      pr2_r  <= pr_c;
      v2_r   <= v1_r;
      r2_2_r <= rs1_r * rs1_r;
      t2_3_r <= t2_c;
      v3_r   <= v2_r;
      r2_3_r <= r2_2_r;
      for (int i = 0; i < 3; i++) begin
        m4_r[i]  <= m_c[i][61:31];
        mn4_r[i] <= t2_3_r[31] ^ unit.neg[i];
        wm5_r[i] <= wmag_c[i][31:0];
        sq6_r[i] <= wm5_r[i] * wm5_r[i];
      end
      v4_r   <= v3_r;
      r2_4_r <= r2_3_r;
      far5_r <= far_c;
      r2_5_r <= r2_4_r;
      far6_r <= far5_r;
      r2_6_r <= r2_5_r;
      hit7_r <= !far6_r && (d2_c < {2'd0, r2_6_r});
    end
  end

  assign valid_out = val_r[6];
  assign hit_out   = hit7_r;

endmodule

// File: src/capsule_sphere_overlap_test.sv
// Capsule-sphere overlap test, top level with configuration registers.
// A hit word passes through seven register stages after the edge that accepts its sphere word;
// throughput one word a cycle while the setup is idle and the output word is not stalled.
// An axis write starts the unit-axis setup (square, root and divide steps; a zero axis
// skips the divide steps); sphere words are stalled meanwhile.
// Synchronous active-low reset clears the configuration registers and the unit axis to zero and the pipeline to empty.
module capsule_sphere_overlap_test (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_sphere_x,
  input  logic signed [31:0] in_sphere_y,
  input  logic signed [31:0] in_sphere_z,
  input  logic [30:0]        in_sphere_radius,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit
);

  logic [2:0][31:0]     center_r;
  logic [2:0][31:0]     axis_r;
  logic [30:0]          seg_len_r;
  logic [30:0]          cap_rad_r;
  logic                 cfg_we;
  logic                 axis_we;
  logic                 en;
  logic                 in_take;
  csot_pkg::unit_axis_t unit;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign axis_we   = cfg_we && (cfg_index inside {csot_pkg::REG_AXIS_X,
                                                  csot_pkg::REG_AXIS_Y,
                                                  csot_pkg::REG_AXIS_Z});

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r  <= '0;
      axis_r    <= '0;
      seg_len_r <= '0;
      cap_rad_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        csot_pkg::REG_CAPSULE_X: center_r[0] <= cfg_data;
        csot_pkg::REG_CAPSULE_Y: center_r[1] <= cfg_data;
        csot_pkg::REG_CAPSULE_Z: center_r[2] <= cfg_data;
        csot_pkg::REG_AXIS_X:    axis_r[0]   <= cfg_data;
        csot_pkg::REG_AXIS_Y:    axis_r[1]   <= cfg_data;
        csot_pkg::REG_AXIS_Z:    axis_r[2]   <= cfg_data;
        csot_pkg::REG_SEG_LEN:   seg_len_r   <= cfg_data[30:0];
        csot_pkg::REG_RADIUS:    cap_rad_r   <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline holds while the output word is stalled.
  assign en       = !(out_valid && out_stall);
  assign in_stall = unit.busy || !en;
  assign in_take  = in_valid && !in_stall;

  csot_setup u_setup (
    .clk   (clk),
    .rst_n (rst_n),
    .start (axis_we),
    .axis  (axis_r),
    .unit  (unit)
  );

  csot_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_take    (in_take),
    .sphere     ({in_sphere_z, in_sphere_y, in_sphere_x}),
    .sphere_rad (in_sphere_radius),
    .center     (center_r),
    .seg_len    (seg_len_r),
    .cap_rad    (cap_rad_r),
    .unit       (unit),
    .valid_out  (out_valid),
    .hit_out    (out_hit)
  );

  // No sphere word enters while the unit axis is being derived.
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    unit.busy |-> !in_take)
    else $error("sphere word accepted during axis setup");

  // An axis write always starts the setup sequencer.
  a_axis_starts: assert property (@(posedge clk) disable iff (!rst_n)
    axis_we |=> unit.busy)
    else $error("axis write did not start setup");

  // The unit axis components never exceed one in Q2.30.
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    !unit.busy |-> (unit.mag[0] <= 31'h4000_0000) && (unit.mag[1] <= 31'h4000_0000)
                   && (unit.mag[2] <= 31'h4000_0000))
    else $error("unit axis component out of range");

endmodule

// File: tb/csot_checker.sv
// Checker for the capsule-sphere overlap test: watches the three channels,
// predicts each hit word from its own copy of the capsule registers and compares.
// Depends on csot_pkg for the register index codes.
`timescale 1ns / 1ps

module csot_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_sphere_x,
  input  logic signed [31:0] in_sphere_y,
  input  logic signed [31:0] in_sphere_z,
  input  logic [30:0]        in_sphere_radius,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_hit,
  output int                 mismatch_count,
  output int                 hits_pending
);

  // Shadow copy of the capsule registers.
  logic signed [31:0] cap_center [3];
  logic signed [31:0] cap_axis [3];
  logic [30:0]        cap_seg_len;
  logic [30:0]        cap_radius;

  bit expected_hits [$];

  function automatic longint unsigned magnitude(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint signed_as(input longint unsigned m, input bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Integer square root, floor, bit by bit.
  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Squared distance from sphere center to the axis segment against the radius sum.
  function automatic bit predict_hit(input logic signed [31:0] sx, input logic signed [31:0] sy,
                                     input logic signed [31:0] sz, input logic [30:0] sr);
    longint          v [3];
    longint          u [3];
    longint          p, t2, lim, w;
    longint unsigned asq, n, am, m, wm, sq, d2, rsum, r2;
    bit              far;
    v[0] = longint'(sx) - longint'(cap_center[0]);
    v[1] = longint'(sy) - longint'(cap_center[1]);
    v[2] = longint'(sz) - longint'(cap_center[2]);
    asq = 0;
    for (int i = 0; i < 3; i++) begin
      am = magnitude(longint'(cap_axis[i]));
      asq += am * am;
    end
    n = floor_root(asq);
    for (int i = 0; i < 3; i++) begin
      am = magnitude(longint'(cap_axis[i]));
      u[i] = (n == 0) ? 0 : signed_as((am << 30) / n, cap_axis[i][31]);
    end
    p = 0;
    for (int i = 0; i < 3; i++) begin
      m = (magnitude(v[i]) * magnitude(u[i])) >> 30;
      p += signed_as(m, (v[i] < 0) != (u[i] < 0));
    end
    // Doubled segment parameter, clamped to the segment ends.
    lim = longint'({33'b0, cap_seg_len});
    t2 = 2 * p;
    if (t2 > lim) t2 = lim;
    if (t2 < -lim) t2 = -lim;
    far = 0;
    d2 = 0;
    for (int i = 0; i < 3; i++) begin
      m = (magnitude(t2) * magnitude(u[i])) >> 31;
      w = v[i] - signed_as(m, (t2 < 0) != (u[i] < 0));
      wm = magnitude(w);
      if (wm >= 64'h1_0000_0000) begin
        far = 1;
      end else begin
        sq = wm * wm;
        if (d2 > 64'hFFFF_FFFF_FFFF_FFFF - sq) d2 = 64'hFFFF_FFFF_FFFF_FFFF;
        else d2 += sq;
      end
    end
    rsum = longint'({33'b0, cap_radius}) + longint'({33'b0, sr});
    r2 = rsum * rsum;
    return !far && (d2 < r2);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  assign hits_pending = expected_hits.size();

  initial mismatch_count = 0;

  // Register writes update the shadow copy; indexes past the last are dropped.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        cap_center[i] = '0;
        cap_axis[i] = '0;
      end
      cap_seg_len = '0;
      cap_radius = '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        csot_pkg::REG_CAPSULE_X: cap_center[0] = cfg_data;
        csot_pkg::REG_CAPSULE_Y: cap_center[1] = cfg_data;
        csot_pkg::REG_CAPSULE_Z: cap_center[2] = cfg_data;
        csot_pkg::REG_AXIS_X:    cap_axis[0] = cfg_data;
        csot_pkg::REG_AXIS_Y:    cap_axis[1] = cfg_data;
        csot_pkg::REG_AXIS_Z:    cap_axis[2] = cfg_data;
        csot_pkg::REG_SEG_LEN:   cap_seg_len = cfg_data[30:0];
        csot_pkg::REG_RADIUS:    cap_radius = cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Predict on each accepted sphere word, compare on each accepted hit word.
  always @(posedge clk) begin
    bit want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_hits.push_back(predict_hit(in_sphere_x, in_sphere_y, in_sphere_z,
                                            in_sphere_radius));
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("hit word with no sphere waiting");
        end else begin
          want = expected_hits.pop_front();
          if (out_hit !== want)
            report_mismatch($sformatf("hit is %b, expected %b", out_hit, want));
        end
      end
    end
  end

endmodule

// File: tb/tb.sv
// Top of the capsule-sphere overlap test bench: clock, reset, register setup and
// sphere stimulus under varied idling and output stalls; csot_checker does the prediction and compare.
`timescale 1ns / 1ps

module tb;

  localparam logic [7:0] REG_PAST_END = 8'd8;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [7:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [31:0] in_sphere_x = '0;
  logic signed [31:0] in_sphere_y = '0;
  logic signed [31:0] in_sphere_z = '0;
  logic [30:0]        in_sphere_radius = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic               out_hit;
  int                 mismatch_count;
  int                 hits_pending;

  int          idle_pct = 0;
  int          stall_pct = 0;
  logic [31:0] ctr [3];

  always #4 clk = ~clk;

  capsule_sphere_overlap_test u_dut (.*);

  csot_checker u_checker (.*);

  // Receiver stalls at random.
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // Wait until every hit word is back and the pipeline has drained.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (hits_pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic load_capsule(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] cz, input logic [31:0] ax,
                              input logic [31:0] ay, input logic [31:0] az,
                              input logic [31:0] len, input logic [31:0] rad);
    drain();
    write_reg(csot_pkg::REG_CAPSULE_X, cx);
    write_reg(csot_pkg::REG_CAPSULE_Y, cy);
    write_reg(csot_pkg::REG_CAPSULE_Z, cz);
    write_reg(csot_pkg::REG_AXIS_X, ax);
    write_reg(csot_pkg::REG_AXIS_Y, ay);
    write_reg(csot_pkg::REG_AXIS_Z, az);
    write_reg(csot_pkg::REG_SEG_LEN, len);
    write_reg(csot_pkg::REG_RADIUS, rad);
    ctr[0] = cx;
    ctr[1] = cy;
    ctr[2] = cz;
  endtask

  // One sphere word, after a random idle gap.
  task automatic send_sphere(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [30:0] r);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid         <= 1;
    in_sphere_x      <= x;
    in_sphere_y      <= y;
    in_sphere_z      <= z;
    in_sphere_radius <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] near_offset();
    int sh;
    sh = $urandom_range(30, 8);
    return ($urandom() >> (32 - sh)) - (32'd1 << (sh - 1));
  endfunction

  // Mostly spheres around the capsule, some anywhere in the field range.
  task automatic random_spheres(input int count);
    logic [31:0] p [3];
    logic [30:0] r;
    for (int k = 0; k < count; k++) begin
      case ((k / 40) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      if (k == count / 2) drain();
      for (int i = 0; i < 3; i++)
        p[i] = ($urandom_range(9) < 7) ? ctr[i] + near_offset() : $urandom();
      r = ($urandom_range(9) < 8) ? 31'($urandom() >> $urandom_range(31, 3))
                                  : 31'($urandom());
      send_sphere(p[0], p[1], p[2], r);
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    ctr[0] = '0;
    ctr[1] = '0;
    ctr[2] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset capsule: a point of zero radius at the origin.
    send_sphere(32'h0, 32'h0, 32'h0, 31'h0);
    send_sphere(32'h0, 32'h0, 32'h0, 31'h1);
    send_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
    send_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_sphere(32'h0001_0000, 32'h0, 32'h0, 31'h0001_0000);
    send_sphere(32'h0001_0000, 32'h0, 32'h0, 31'h0001_0001);

    // Unit axis along x, length 4, radius 1; ends and sides of the segment.
    load_capsule(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0004_0000,
                 32'h0001_0000);
    write_reg(REG_PAST_END, 32'hFFFF_FFFF);
    write_reg(8'hFF, 32'h1234_5678);
    send_sphere(32'h0002_0000, 32'h0, 32'h0, 31'h0);
    send_sphere(32'h0003_0000, 32'h0, 32'h0, 31'h0);
    send_sphere(32'hFFFD_0000, 32'h0, 32'h0, 31'h0);
    send_sphere(32'h0001_0000, 32'h0002_0000, 32'h0, 31'h0001_0000);
    send_sphere(32'h0001_0000, 32'h0002_0000, 32'h0, 31'h0000_FFFF);
    send_sphere(32'h0, 32'h0, 32'h0001_0000, 31'h0);
    send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 31'h7FFF_FFFF);
    random_spheres(250);

    // Tilted axis of arbitrary length, zero length segment.
    load_capsule(32'h0010_0000, 32'hFFF0_0000, 32'h0003_8000, 32'h0002_0000,
                 32'hFFFF_0000, 32'h0003_0000, 32'h0, 32'h0002_0000);
    random_spheres(250);

    // Extremes: corner center, full-scale axis, longest segment, widest radius.
    load_capsule(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0);
    random_spheres(250);

    // Zero axis with a long segment: still a point.
    load_capsule(32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
                 32'h7FFF_FFFF, 32'h0100_0000);
    random_spheres(250);

    // Random capsules, small axes, short segments.
    for (int s = 0; s < 4; s++) begin
      load_capsule($urandom() >> 4, $urandom() >> 4, $urandom() >> 4,
                   near_offset(), near_offset(), near_offset(),
                   $urandom() >> $urandom_range(12, 1), $urandom() >> $urandom_range(12, 4));
      random_spheres(70);
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
